FILE: hw/rtl/differential_wheel_speed_mixer_assert.svh
// assertion macros for the differential wheel speed mixer
`ifndef DIFFERENTIAL_WHEEL_SPEED_MIXER_ASSERT_SVH
`define DIFFERENTIAL_WHEEL_SPEED_MIXER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define DWSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dwsm same-cycle check failed");

// next-cycle implication, checked out of reset
`define DWSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dwsm next-cycle check failed");

`else

`define DWSM_ASSERT_NOW(label, ante, cons)
`define DWSM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/dwsm_pkg.sv
// constants, types and arithmetic helpers of the wheel speed mixer
package dwsm_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned SpeedW = 10;
  localparam int unsigned DeltaW = 11;
  localparam int unsigned WheelW = 9;
  localparam int unsigned AchW   = 10;
  localparam int unsigned MaxW   = 8;
  localparam int unsigned CalcW  = 12;

  localparam logic [MaxW-1:0] MaxSpeedReset = 8'd128;

  // command codes
  localparam logic [CmdW-1:0] CMD_SET_SPEED = 2'd0;
  localparam logic [CmdW-1:0] CMD_SET_DELTA = 2'd1;
  localparam logic [CmdW-1:0] CMD_STOP      = 2'd2;

  typedef logic signed [CalcW-1:0] calc_t;

  // limit a value to [lo, hi]
  function automatic calc_t clamp(calc_t v, calc_t lo, calc_t hi);
    calc_t r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // magnitude
  function automatic calc_t absv(calc_t v);
    return (v < 0) ? -v : v;
  endfunction

  // halving that truncates toward zero
  function automatic calc_t half(calc_t v);
    calc_t t;
    t = v + {{(CalcW-1){1'b0}}, v[CalcW-1]};
    return t >>> 1;
  endfunction

endpackage

FILE: hw/rtl/differential_wheel_speed_mixer.sv
// Differential wheel speed mixer: top level
//
// Keeps left, right and average wheel speeds (ticks per second). Each input
// transaction carries a command: set average speed, set right-minus-left
// difference, or stop. Results are limited to the configured max speed.
// Input channel: in_valid_i / in_ready_o with cmd_i, speed_i, delta_i.
// Output channel: out_valid_o / out_ready_i with left, right and average
// speed and the achieved value (difference kept or average kept).
// Config channel: cfg_valid_i / cfg_ready_o with cfg_max_speed_i; always
// ready; the user must write it only while no transaction is in flight,
// which the block does not enforce. Input accept loads the input register,
// and one combinational pass feeds the result and wheel state registers.
// Throughput: one transaction per cycle while the output is taken; each
// command sees the previous outcome; the result register holds the speeds.
// Reset: speeds clear to zero, max speed returns to 128, both stages empty.
// Stall: a held output blocks the pass; the input register still takes one
// more transaction, then in_ready_o drops until the output is taken.
`include "differential_wheel_speed_mixer_assert.svh"

module differential_wheel_speed_mixer
  import dwsm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CmdW-1:0]          cmd_i,
  input  logic signed [SpeedW-1:0] speed_i,
  input  logic signed [DeltaW-1:0] delta_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [WheelW-1:0] left_speed_o,
  output logic signed [WheelW-1:0] right_speed_o,
  output logic signed [WheelW-1:0] average_speed_o,
  output logic signed [AchW-1:0]   achieved_o,
  // configuration channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [MaxW-1:0]          cfg_max_speed_i
);

  // input stage
  logic                     in_valid_q;
  logic [CmdW-1:0]          cmd_q;
  logic signed [SpeedW-1:0] speed_q;
  logic signed [DeltaW-1:0] delta_q;

  // result stage, doubles as the wheel state
  logic                     out_valid_q;
  logic signed [WheelW-1:0] left_q, left_d;
  logic signed [WheelW-1:0] right_q, right_d;
  logic signed [WheelW-1:0] mean_q, mean_d;
  logic signed [AchW-1:0]   ach_q, ach_d;

  logic [MaxW-1:0] max_speed_q;

  logic  advance;
  calc_t m, m2;
  calc_t cur_l, cur_r, cur_mean;
  calc_t req_s, req_d;
  calc_t s_c, hi_s, d_s, r_s, l_s;
  calc_t d_c, hd, hi_d, avg_c, r_d, l_d;
  calc_t new_l, new_r, new_mean, new_ach;

  // pipeline control
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // operand extension
  assign m        = {{(CalcW-MaxW){1'b0}}, max_speed_q};
  assign m2       = m <<< 1;
  assign cur_l    = {{(CalcW-WheelW){left_q[WheelW-1]}}, left_q};
  assign cur_r    = {{(CalcW-WheelW){right_q[WheelW-1]}}, right_q};
  assign cur_mean = {{(CalcW-WheelW){mean_q[WheelW-1]}}, mean_q};
  assign req_s    = {{(CalcW-SpeedW){speed_q[SpeedW-1]}}, speed_q};
  assign req_d    = {{(CalcW-DeltaW){delta_q[DeltaW-1]}}, delta_q};

  // set speed: keep the difference, shrunk to fit the limit
  always_comb begin
    s_c  = clamp(req_s, -m, m);
    hi_s = (m - absv(s_c)) <<< 1;
    d_s  = clamp(cur_r - cur_l, -hi_s, hi_s);
    r_s  = s_c + half(d_s);
    l_s  = clamp(r_s - d_s, -m, m);
  end

  // set delta: keep the average, lowered to fit the limit
  always_comb begin
    d_c   = clamp(req_d, -m2, m2);
    hd    = half(d_c);
    hi_d  = m - absv(hd);
    avg_c = clamp(cur_mean, -hi_d, hi_d);
    r_d   = avg_c + hd;
    l_d   = clamp(r_d - d_c, -m, m);
  end

  // command select
  always_comb begin
    new_l    = cur_l;
    new_r    = cur_r;
    new_mean = cur_mean;
    new_ach  = '0;
    case (cmd_q)
      CMD_SET_SPEED: begin
        new_l    = l_s;
        new_r    = r_s;
        new_mean = half(l_s + r_s);
        new_ach  = d_s;
      end
      CMD_SET_DELTA: begin
        new_l    = l_d;
        new_r    = r_d;
        new_mean = half(l_d + r_d);
        new_ach  = new_mean;
      end
      CMD_STOP: begin
        new_l    = '0;
        new_r    = '0;
        new_mean = '0;
        new_ach  = '0;
      end
      default: begin
        new_ach = '0;
      end
    endcase
    left_d  = new_l[WheelW-1:0];
    right_d = new_r[WheelW-1:0];
    mean_d  = new_mean[WheelW-1:0];
    ach_d   = new_ach[AchW-1:0];
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= cmd_i;
      speed_q <= speed_i;
      delta_q <= delta_i;
    end
  end

  // result and wheel state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      mean_q      <= '0;
      ach_q       <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        left_q      <= left_d;
        right_q     <= right_d;
        mean_q      <= mean_d;
        ach_q       <= ach_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // max speed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MaxSpeedReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_speed_q <= cfg_max_speed_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_speed_o    = left_q;
  assign right_speed_o   = right_q;
  assign average_speed_o = mean_q;
  assign achieved_o      = ach_q;

  // checks
  `DWSM_ASSERT_NOW(a_ready_only_when_full, !in_ready_o, in_valid_q && out_valid_q)
  `DWSM_ASSERT_NEXT(a_stop_clears, advance && (cmd_q == CMD_STOP),
                    left_q == '0 && right_q == '0 && mean_q == '0 && ach_q == '0)
  `DWSM_ASSERT_NOW(a_achieved_range, out_valid_o,
                   achieved_o >= -10'sd510 && achieved_o <= 10'sd510)

endmodule

FILE: verif/differential_wheel_speed_mixer_tb.sv
// self-checking testbench for the differential wheel speed mixer
`timescale 1ns / 1ps

module differential_wheel_speed_mixer_tb
  import dwsm_pkg::*;
;

  // the command code that the block treats as a read-back of its state
  localparam logic [CmdW-1:0] CMD_HOLD = 2'd3;
  localparam int CycleLimit = 500000;
  localparam int HoldOffCycles = 100;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

  typedef struct {
    logic signed [WheelW-1:0] left_spd;
    logic signed [WheelW-1:0] right_spd;
    logic signed [WheelW-1:0] avg_spd;
    logic signed [AchW-1:0]   ach;
  } wheel_result_t;

  typedef struct {
    row_kind_e       kind;
    logic [CmdW-1:0] op;
    int              spd;
    int              dlt;
    int              max_val;
    bit              typed;
    int              left_spd;
    int              right_spd;
    int              avg_spd;
    int              ach;
  } row_t;

  // directed stimulus: extremes, every command, truncation, limit changes
  row_t dir_rows [0:23] = '{
    '{ROW_CMD, CMD_STOP,      511,   1023, 0,   1, 0, 0, 0, 0},
    '{ROW_CMD, CMD_SET_SPEED, 511,   0,    0,   1, 128, 128, 128, 0},
    '{ROW_CMD, CMD_SET_SPEED, -512,  0,    0,   1, -128, -128, -128, 0},
    '{ROW_CMD, CMD_SET_DELTA, 0,     1023, 0,   1, -128, 128, 0, 0},
    '{ROW_CMD, CMD_SET_SPEED, 0,     0,    0,   1, -128, 128, 0, 256},
    '{ROW_CMD, CMD_SET_DELTA, 0,     -1024, 0,  1, 128, -128, 0, 0},
    '{ROW_CMD, CMD_HOLD,      5,     7,    0,   1, 128, -128, 0, 0},
    '{ROW_CMD, CMD_SET_SPEED, 64,    0,    0,   0, 0, 0, 0, 0},
    '{ROW_CMD, CMD_SET_DELTA, 0,     3,    0,   0, 0, 0, 0, 0},
    '{ROW_CMD, CMD_SET_DELTA, 0,     -3,   0,   0, 0, 0, 0, 0},
    '{ROW_CMD, CMD_SET_SPEED, -1,    0,    0,   0, 0, 0, 0, 0},
    '{ROW_CMD, CMD_SET_DELTA, 0,     0,    0,   0, 0, 0, 0, 0},
    '{ROW_CMD, CMD_SET_SPEED, 127,   -1,   0,   0, 0, 0, 0, 0},
    '{ROW_CMD, CMD_STOP,      -512,  -1024, 0,  1, 0, 0, 0, 0},
    '{ROW_CFG, CMD_STOP,      0,     0,    255, 0, 0, 0, 0, 0},
    '{ROW_CMD, CMD_SET_SPEED, 511,   0,    0,   1, 255, 255, 255, 0},
    '{ROW_CMD, CMD_SET_DELTA, 0,     -1024, 0,  1, 255, -255, 0, 0},
    '{ROW_CFG, CMD_STOP,      0,     0,    40,  0, 0, 0, 0, 0},
    '{ROW_CMD, CMD_HOLD,      0,     0,    0,   1, 255, -255, 0, 0},
    '{ROW_CMD, CMD_SET_SPEED, 0,     0,    0,   1, 40, -40, 0, -80},
    '{ROW_CFG, CMD_STOP,      0,     0,    0,   0, 0, 0, 0, 0},
    '{ROW_CMD, CMD_SET_SPEED, 100,   0,    0,   1, 0, 0, 0, 0},
    '{ROW_CMD, CMD_SET_DELTA, 0,     5,    0,   1, 0, 0, 0, 0},
    '{ROW_CFG, CMD_STOP,      0,     0,    128, 0, 0, 0, 0, 0}
  };

  int phase_max [8] = '{128, 255, 0, 1, 128, 200, 128, 128};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CmdW-1:0]          cmd = CMD_STOP;
  logic signed [SpeedW-1:0] speed = '0;
  logic signed [DeltaW-1:0] delta = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [WheelW-1:0] left_speed;
  logic signed [WheelW-1:0] right_speed;
  logic signed [WheelW-1:0] average_speed;
  logic signed [AchW-1:0]   achieved;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [MaxW-1:0]          cfg_max_speed = '0;

  // predictor state and configuration
  int              wheel_left = 0;
  int              wheel_right = 0;
  int              wheel_mean = 0;
  logic [MaxW-1:0] max_speed_q = MaxSpeedReset;

  wheel_result_t pending_q [$];
  int            n_fail = 0;
  int            cycle_count = 0;
  bit            src_idle_on = 1'b0;
  bit            snk_idle_on = 1'b0;
  bit            hold_req = 1'b0;

  differential_wheel_speed_mixer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .cmd_i           (cmd),
    .speed_i         (speed),
    .delta_i         (delta),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .left_speed_o    (left_speed),
    .right_speed_o   (right_speed),
    .average_speed_o (average_speed),
    .achieved_o      (achieved),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_max_speed_i (cfg_max_speed)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  // next wheel speeds for one command; integer division truncates toward zero
  function automatic wheel_result_t apply_command(logic [CmdW-1:0] op,
                                                  logic signed [SpeedW-1:0] spd,
                                                  logic signed [DeltaW-1:0] dlt);
    int m;
    int s;
    int d;
    int hi;
    int avg;
    int ach;
    wheel_result_t res;
    m = int'(max_speed_q);
    ach = 0;
    case (op)
      CMD_SET_SPEED: begin
        s = clip(int'(spd), -m, m);
        hi = 2 * (m - mag(s));
        d = clip(wheel_right - wheel_left, -hi, hi);
        wheel_right = s + d / 2;
        wheel_left = clip(wheel_right - d, -m, m);
        wheel_mean = (wheel_left + wheel_right) / 2;
        ach = d;
      end
      CMD_SET_DELTA: begin
        d = clip(int'(dlt), -2 * m, 2 * m);
        hi = m - mag(d / 2);
        avg = clip(wheel_mean, -hi, hi);
        wheel_right = avg + d / 2;
        wheel_left = clip(wheel_right - d, -m, m);
        wheel_mean = (wheel_right + wheel_left) / 2;
        ach = wheel_mean;
      end
      CMD_STOP: begin
        wheel_left = 0;
        wheel_right = 0;
        wheel_mean = 0;
      end
      default: ;
    endcase
    res.left_spd = wheel_left[WheelW-1:0];
    res.right_spd = wheel_right[WheelW-1:0];
    res.avg_spd = wheel_mean[WheelW-1:0];
    res.ach = ach[AchW-1:0];
    return res;
  endfunction

  // offer one command and hold it until the block takes it
  task automatic offer(input logic [CmdW-1:0] op, input logic signed [SpeedW-1:0] spd,
                       input logic signed [DeltaW-1:0] dlt, input bit typed,
                       input wheel_result_t typed_res);
    wheel_result_t res;
    in_valid <= 1'b1;
    cmd <= op;
    speed <= spd;
    delta <= dlt;
    do @(posedge clk); while (!in_ready);
    res = apply_command(op, spd, dlt);
    pending_q.push_back(typed ? typed_res : res);
  endtask

  // stop offering and wait until every expected result is out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // write max speed once the block has gone idle
  task automatic write_max_speed(input int value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_max_speed <= value[MaxW-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_speed_q = value[MaxW-1:0];
  endtask

  // result receiver: random stalls plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    wheel_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result left %0d right %0d avg %0d achieved %0d",
                 $time, left_speed, right_speed, average_speed, achieved);
        n_fail++;
      end else begin
        want = pending_q.pop_front();
        if (left_speed !== want.left_spd) begin
          $display("%0t: left_speed expected %0d got %0d", $time, want.left_spd, left_speed);
          n_fail++;
        end
        if (right_speed !== want.right_spd) begin
          $display("%0t: right_speed expected %0d got %0d", $time, want.right_spd,
                   right_speed);
          n_fail++;
        end
        if (average_speed !== want.avg_spd) begin
          $display("%0t: average_speed expected %0d got %0d", $time, want.avg_spd,
                   average_speed);
          n_fail++;
        end
        if (achieved !== want.ach) begin
          $display("%0t: achieved expected %0d got %0d", $time, want.ach, achieved);
          n_fail++;
        end
      end
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Test completed with failures");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int p;
    int k;
    int mx;
    int n_items;
    int r;
    int tmp;
    logic [CmdW-1:0] op;
    logic signed [SpeedW-1:0] spd;
    logic signed [DeltaW-1:0] dlt;
    wheel_result_t typed_res;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_max_speed(dir_rows[i].max_val);
      end else begin
        typed_res.left_spd = dir_rows[i].left_spd[WheelW-1:0];
        typed_res.right_spd = dir_rows[i].right_spd[WheelW-1:0];
        typed_res.avg_spd = dir_rows[i].avg_spd[WheelW-1:0];
        typed_res.ach = dir_rows[i].ach[AchW-1:0];
        offer(dir_rows[i].op, dir_rows[i].spd[SpeedW-1:0], dir_rows[i].dlt[DeltaW-1:0],
              dir_rows[i].typed, typed_res);
      end
    end

    // random phases, each under its own max speed
    for (p = 0; p < 8; p++) begin
      mx = (p == 4 || p == 6) ? $urandom_range(0, 255) : phase_max[p];
      write_max_speed(mx);
      src_idle_on = (p != 3 && p != 7);
      snk_idle_on = (p != 7);
      n_items = (mx <= 1) ? 60 : 260;
      for (k = 0; k < n_items; k++) begin
        // long receiver hold-off while commands keep coming
        if (p == 1 && k == 40) hold_req = 1'b1;
        // pause until the block has delivered everything
        if (p == 5 && k == 130) drain_results();
        if (src_idle_on && !hold_req && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        r = $urandom_range(0, 99);
        if (r < 40) op = CMD_SET_SPEED;
        else if (r < 80) op = CMD_SET_DELTA;
        else if (r < 90) op = CMD_STOP;
        else op = CMD_HOLD;
        // half the values anywhere in the field, half within the limits or just past them
        if ($urandom_range(0, 1)) begin
          tmp = $urandom;
        end else begin
          tmp = $urandom_range(0, 2 * mx + 4);
          tmp = tmp - mx - 2;
        end
        spd = tmp[SpeedW-1:0];
        if ($urandom_range(0, 1)) begin
          tmp = $urandom;
        end else begin
          tmp = $urandom_range(0, 4 * mx + 4);
          tmp = tmp - 2 * mx - 2;
        end
        dlt = tmp[DeltaW-1:0];
        offer(op, spd, dlt, 1'b0, typed_res);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
